[design/lats_pkg.sv]
// Shared types, register indexes and tone codes of the level alarm tone sequencer.
`timescale 1ns / 1ps
`default_nettype none
package lats_pkg;

   // Default chime tone durations in milliseconds.
   localparam logic [15:0] LATS_CHIME_C_MS = 16'd150;
   localparam logic [15:0] LATS_CHIME_E_MS = 16'd200;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDER_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WATER_LOW   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TONE_A      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TONE_E      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TONE_GAP    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESOLVED_GAP = 3'd7;

   // Tone action codes.
   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_STOP  = 2'd2;

   // Tone select codes.
   localparam logic [1:0] SEL_ALARM_A = 2'd0;
   localparam logic [1:0] SEL_ALARM_E = 2'd1;
   localparam logic [1:0] SEL_CHIME_C = 2'd2;
   localparam logic [1:0] SEL_CHIME_E = 2'd3;

   // Chime steps; the fourth code is never entered.
   localparam logic [1:0] CHIME_START_C  = 2'd0;
   localparam logic [1:0] CHIME_WAIT_E   = 2'd1;
   localparam logic [1:0] CHIME_WAIT_END = 2'd2;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [9:0]  feeder_level;
      logic [9:0]  water_level;
   } req_type;

   typedef struct packed {
      logic [1:0]  tone_action;
      logic [1:0]  tone_select;
      logic [15:0] tone_duration_ms;
      logic        alarm_now;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  feeder_low_threshold;
      logic [9:0]  water_low_threshold;
      logic [31:0] alert_interval_ms;
      logic [31:0] alert_window_ms;
      logic [15:0] tone_a_ms;
      logic [15:0] tone_e_ms;
      logic [15:0] tone_gap_ms;
      logic [15:0] resolved_gap_ms;
   } cfg_type;

   typedef struct packed {
      logic        alarm_latched;
      logic [31:0] phase_start;
      logic [31:0] cycle_start;
      logic        pattern_second;
      logic        sounding;
      logic        chime_active;
      logic [1:0]  chime_step;
      logic [31:0] chime_phase_start;
   } state_type;

endpackage
`default_nettype wire

[design/level_alarm_tone_sequencer.sv]
// Top level of the level alarm tone sequencer: input register, step logic, result register.
// An accepted beat is held in the input register and its result in the result register.
// Throughput: one beat per cycle while rsp_stall is low; the tick step is a single pass
// of compares and 32-bit subtracts between the input register and the result register.
// Reset is synchronous and active high; it empties both registers, clears the
// sequencer state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module level_alarm_tone_sequencer
   import lats_pkg::*;
#(
   parameter logic [15:0] CHIME_C_MS = LATS_CHIME_C_MS,
   parameter logic [15:0] CHIME_E_MS = LATS_CHIME_E_MS
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  req_type                     req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_wdata
);

   cfg_type   cfg;
   state_type state_ff;
   state_type state_in;
   rsp_type   result;

   // Input register. It holds one tick until the step logic can hand its
   // result to the result register.
   logic    in_valid_ff;
   req_type in_ff;

   // Result register. While it holds a stalled beat the input register keeps
   // its tick, so one more beat can be taken before the input side stalls.
   logic    out_valid_ff;
   rsp_type out_ff;

   logic advance;
   logic accept;

   lats_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lats_step #(
      .CHIME_C_MS (CHIME_C_MS),
      .CHIME_E_MS (CHIME_E_MS)
   ) u_step (
      .item       (in_ff),
      .cfg        (cfg),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result)
   );

   // The held tick moves on when the result register is empty or is being
   // emptied at this edge. The sequencer state commits at the same edge, so
   // each tick sees the state left by the one before it.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // The input side only stalls behind a stalled result beat.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result beat");

   // Select and duration are zero unless a tone starts.
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.tone_action != ACT_START)) |->
      ((rsp_data.tone_select == SEL_ALARM_A) && (rsp_data.tone_duration_ms == 16'd0)))
      else $error("tone fields set on a beat that starts no tone");

   // The chime only runs while the alarm is clear.
   a_chime_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff.chime_active |-> !state_ff.alarm_latched)
      else $error("chime active while alarm latched");

   // A committed tick always leaves a result beat behind it.
   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("tick committed without a result beat");

endmodule
`default_nettype wire

[design/lats_csr.sv]
// Configuration register file of the level alarm tone sequencer.
`timescale 1ns / 1ps
`default_nettype none
module lats_csr
   import lats_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.feeder_low_threshold <= 10'd200;
         cfg_ff.water_low_threshold  <= 10'd200;
         cfg_ff.alert_interval_ms    <= 32'd60000;
         cfg_ff.alert_window_ms      <= 32'd3000;
         cfg_ff.tone_a_ms            <= 16'd200;
         cfg_ff.tone_e_ms            <= 16'd200;
         cfg_ff.tone_gap_ms          <= 16'd100;
         cfg_ff.resolved_gap_ms      <= 16'd150;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FEEDER_LOW:   cfg_ff.feeder_low_threshold <= csr_wdata[9:0];
            CSR_WATER_LOW:    cfg_ff.water_low_threshold  <= csr_wdata[9:0];
            CSR_INTERVAL:     cfg_ff.alert_interval_ms    <= csr_wdata;
            CSR_WINDOW:       cfg_ff.alert_window_ms      <= csr_wdata;
            CSR_TONE_A:       cfg_ff.tone_a_ms            <= csr_wdata[15:0];
            CSR_TONE_E:       cfg_ff.tone_e_ms            <= csr_wdata[15:0];
            CSR_TONE_GAP:     cfg_ff.tone_gap_ms          <= csr_wdata[15:0];
            CSR_RESOLVED_GAP: cfg_ff.resolved_gap_ms      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[design/lats_step.sv]
// Next-state and result logic for one service tick of the tone sequencer.
`timescale 1ns / 1ps
`default_nettype none
module lats_step
   import lats_pkg::*;
#(
   parameter logic [15:0] CHIME_C_MS = LATS_CHIME_C_MS,
   parameter logic [15:0] CHIME_E_MS = LATS_CHIME_E_MS
)
(
   input  req_type   item,
   input  cfg_type   cfg,
   input  state_type state,
   output state_type state_next,
   output rsp_type   result
);

   logic        alarm;
   logic [31:0] cyc;
   logic [31:0] el;
   logic [31:0] chime_el;
   logic        restart;
   logic        out_window;
   logic        pattern_eff;
   logic [15:0] target;
   logic        tone_done;
   logic        gap_done;

   assign alarm = (item.feeder_level <= cfg.feeder_low_threshold) ||
                  (item.water_level <= cfg.water_low_threshold);

   // All compares run in parallel. On an interval restart the elapsed times
   // are zero, so the window, tone and gap tests check limits against zero.
   assign cyc         = item.now_ms - state.cycle_start;
   assign el          = item.now_ms - state.phase_start;
   assign chime_el    = item.now_ms - state.chime_phase_start;
   assign restart     = cyc >= cfg.alert_interval_ms;
   assign out_window  = restart ? (cfg.alert_window_ms == 32'd0)
                                : (cyc >= cfg.alert_window_ms);
   assign pattern_eff = restart ? 1'b0 : state.pattern_second;
   assign target      = pattern_eff ? cfg.tone_e_ms : cfg.tone_a_ms;
   assign tone_done   = restart ? (target == 16'd0) : (el >= {16'd0, target});
   assign gap_done    = restart ? (cfg.tone_gap_ms == 16'd0)
                                : (el >= {16'd0, cfg.tone_gap_ms});

   always_comb begin
      state_next              = state;
      result.tone_action      = ACT_NONE;
      result.tone_select      = SEL_ALARM_A;
      result.tone_duration_ms = 16'd0;
      result.alarm_now        = alarm;

      if (alarm != state.alarm_latched) begin
         state_next.alarm_latched  = alarm;
         state_next.phase_start    = item.now_ms;
         state_next.cycle_start    = item.now_ms;
         state_next.pattern_second = 1'b0;
         state_next.chime_step     = CHIME_START_C;
         if (alarm) begin
            state_next.chime_active = 1'b0;
            state_next.sounding     = 1'b1;
            result.tone_action      = ACT_START;
         end else begin
            state_next.sounding          = 1'b0;
            state_next.chime_active      = 1'b1;
            state_next.chime_phase_start = item.now_ms;
            result.tone_action           = ACT_STOP;
         end
      end else if (alarm) begin
         if (restart) begin
            state_next.cycle_start    = item.now_ms;
            state_next.phase_start    = item.now_ms;
            state_next.pattern_second = 1'b0;
         end
         if (out_window) begin
            if (state.sounding) begin
               state_next.sounding = 1'b0;
               result.tone_action  = ACT_STOP;
            end
         end else if (state.sounding) begin
            if (tone_done) begin
               state_next.sounding       = 1'b0;
               state_next.phase_start    = item.now_ms;
               state_next.pattern_second = !pattern_eff;
               result.tone_action        = ACT_STOP;
            end
         end else if (gap_done) begin
            state_next.sounding    = 1'b1;
            state_next.phase_start = item.now_ms;
            result.tone_action     = ACT_START;
            result.tone_select     = pattern_eff ? SEL_ALARM_E : SEL_ALARM_A;
         end
      end else if (state.sounding) begin
         state_next.sounding = 1'b0;
         result.tone_action  = ACT_STOP;
      end else if (state.chime_active) begin
         unique case (state.chime_step)
            CHIME_START_C: begin
               state_next.chime_step        = CHIME_WAIT_E;
               state_next.chime_phase_start = item.now_ms;
               result.tone_action           = ACT_START;
               result.tone_select           = SEL_CHIME_C;
               result.tone_duration_ms      = CHIME_C_MS;
            end
            CHIME_WAIT_E: begin
               if (chime_el >= {16'd0, cfg.resolved_gap_ms}) begin
                  state_next.chime_step        = CHIME_WAIT_END;
                  state_next.chime_phase_start = item.now_ms;
                  result.tone_action           = ACT_START;
                  result.tone_select           = SEL_CHIME_E;
                  result.tone_duration_ms      = CHIME_E_MS;
               end
            end
            CHIME_WAIT_END: begin
               if (chime_el >= {16'd0, CHIME_E_MS}) begin
                  state_next.chime_active      = 1'b0;
                  state_next.chime_step        = CHIME_START_C;
                  state_next.chime_phase_start = item.now_ms;
                  result.tone_action           = ACT_STOP;
               end
            end
            default: begin
               state_next.chime_active = 1'b0;
               state_next.chime_step   = CHIME_START_C;
            end
         endcase
      end
   end

endmodule
`default_nettype wire
